@@ rtl/core/pptb_pkg.sv @@
// Shared types and constants for the point projection and tile binning block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pptb_pkg;

  localparam int unsigned COORD_W  = 32;  // Q-format point and coefficient width
  localparam int unsigned SUM_W    = 64;  // exact width of a dot product
  localparam int unsigned CLIP_W   = 48;  // saturated clip value width
  localparam int unsigned NUM_W    = 64;  // pixel numerator width
  localparam int unsigned DEN_W    = 49;  // |2 * w| fits here
  localparam int unsigned QUO_W    = 14;  // rounded pixel plus its carry at the largest image
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned ADDR_W   = 6;   // byte address, 8 bytes per register
  localparam int unsigned NUM_ROWS = 4;

  // Row order inside the datapath.
  localparam int unsigned ROW_X     = 0;
  localparam int unsigned ROW_Y     = 1;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned ROW_DEPTH = 3;

  localparam logic signed [SUM_W-1:0] CLIP_HI = (SUM_W'(64'sd1) <<< (CLIP_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0] CLIP_LO = -CLIP_HI - 1;

  typedef enum logic [1:0] {
    CULL_NONE      = 2'd0,
    CULL_NEAR      = 2'd1,
    CULL_WZERO     = 2'd2,
    CULL_OFFSCREEN = 2'd3
  } cull_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic        visible;
    cull_e       cull_reason;
    logic [10:0] tile_index;
    logic [5:0]  tile_column;
    logic [5:0]  tile_row;
  } result_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] depth;
    logic signed [SUM_W-1:0] clip_x;
    logic signed [SUM_W-1:0] clip_y;
    logic signed [SUM_W-1:0] clip_w;
  } dot_sums_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [DEN_W-1:0] den;
    logic             bad_x;
    logic             bad_y;
    cull_e            reason;
  } div_in_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic [DEN_W-1:0] rem_x;
    logic [DEN_W-1:0] rem_y;
    logic [DEN_W-1:0] den;
    logic             ovf_x;
    logic             ovf_y;
    cull_e            reason;
  } div_out_t;

  // Clamp an exact sum to the signed clip range.
  function automatic logic signed [CLIP_W-1:0] sat_clip(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > CLIP_HI) r = CLIP_HI;
    if (v < CLIP_LO) r = CLIP_LO;
    return CLIP_W'(r);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pptb_dot.sv @@
// Two-stage dot product unit: twelve registered products, then four row sums.
// Depends on pptb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pptb_dot #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  logic                                                     en_i,
  input  logic                                                     valid_i,
  input  pptb_pkg::point_t                                         point_i,
  input  logic [pptb_pkg::NUM_REGS-1:0][pptb_pkg::CFG_W-1:0]       cfg_i,
  output logic                                                     valid_o,
  output pptb_pkg::dot_sums_t                                      sums_o
);
  import pptb_pkg::*;

  logic signed [COORD_W-1:0] coord [3];
  logic signed [COORD_W-1:0] coef  [NUM_ROWS][4];
  logic signed [SUM_W-1:0]   prod_q [NUM_ROWS][3];
  logic signed [COORD_W-1:0] bias_q [NUM_ROWS];
  logic signed [SUM_W-1:0]   sum_d  [NUM_ROWS];
  logic signed [SUM_W-1:0]   sum_q  [NUM_ROWS];
  logic                      va_q, vb_q;

  always_comb begin
    coord[0] = point_i.point_x;
    coord[1] = point_i.point_y;
    coord[2] = point_i.point_z;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < 4; k++) begin
        coef[r][k] = cfg_i[2*r + k/2][32*(k%2) +: 32];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_d[r] = (prod_q[r][0] >>> FRACTION_BITS) + (prod_q[r][1] >>> FRACTION_BITS)
               + (prod_q[r][2] >>> FRACTION_BITS) + SUM_W'(bias_q[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= SUM_W'(coef[r][k]) * SUM_W'(coord[k]);
        end
        bias_q[r] <= coef[r][3];
        sum_q[r]  <= sum_d[r];
      end
    end
  end

  assign valid_o       = vb_q;
  assign sums_o.clip_x = sum_q[ROW_X];
  assign sums_o.clip_y = sum_q[ROW_Y];
  assign sums_o.clip_w = sum_q[ROW_W];
  assign sums_o.depth  = sum_q[ROW_DEPTH];

endmodule

`default_nettype wire

@@ rtl/core/pptb_prep.sv @@
// Three-stage preparation: saturate and early culls, pixel numerators, sign fix.
// Depends on pptb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pptb_prep #(
  parameter int unsigned IMAGE_WIDTH   = 1280,
  parameter int unsigned IMAGE_HEIGHT  = 720,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  pptb_pkg::dot_sums_t sums_i,
  output logic                valid_o,
  output pptb_pkg::div_in_t   div_o
);
  import pptb_pkg::*;

  localparam int unsigned DW = SUM_W + 3;
  localparam logic signed [DW-1:0]    NEAR_LIM = DW'(64'sd1) <<< FRACTION_BITS;
  localparam logic signed [NUM_W-1:0] SCALE_X  = NUM_W'(IMAGE_WIDTH);
  localparam logic signed [NUM_W-1:0] SCALE_Y  = NUM_W'(IMAGE_HEIGHT);

  // Stage 3
  logic signed [DW-1:0]     depth5;
  logic signed [CLIP_W-1:0] cx_s, cy_s, cw_s;
  cull_e                    reason_d;
  logic signed [CLIP_W:0]   sx_q, sy_q;
  logic signed [CLIP_W-1:0] cw_q;
  cull_e                    r3_q;
  // Stage 4
  logic signed [CLIP_W:0]   d2;
  logic signed [NUM_W-1:0]  nx_q, ny_q;
  logic [DEN_W-1:0]         den4_q;
  logic                     neg_q;
  cull_e                    r4_q;
  // Stage 5
  logic signed [NUM_W-1:0]  nx_f, ny_f;
  div_in_t                  div_q;
  logic [2:0]               v_q;

  always_comb begin
    depth5 = (DW'(sums_i.depth) <<< 2) + DW'(sums_i.depth);
    cx_s   = sat_clip(sums_i.clip_x);
    cy_s   = sat_clip(sums_i.clip_y);
    cw_s   = sat_clip(sums_i.clip_w);
    if (depth5 <= NEAR_LIM) begin
      reason_d = CULL_NEAR;
    end else if (cw_s == '0) begin
      reason_d = CULL_WZERO;
    end else begin
      reason_d = CULL_NONE;
    end
    d2   = (CLIP_W+1)'(cw_q) <<< 1;
    nx_f = neg_q ? -nx_q : nx_q;
    ny_f = neg_q ? -ny_q : ny_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= (CLIP_W+1)'(cx_s) + (CLIP_W+1)'(cw_s);
      sy_q <= (CLIP_W+1)'(cy_s) + (CLIP_W+1)'(cw_s);
      cw_q <= cw_s;
      r3_q <= reason_d;

      nx_q   <= NUM_W'(sx_q) * SCALE_X - NUM_W'(cw_q);
      ny_q   <= NUM_W'(sy_q) * SCALE_Y - NUM_W'(cw_q);
      den4_q <= cw_q[CLIP_W-1] ? DEN_W'(-d2) : DEN_W'(d2);
      neg_q  <= cw_q[CLIP_W-1];
      r4_q   <= r3_q;

      div_q.num_x  <= nx_f;
      div_q.num_y  <= ny_f;
      div_q.bad_x  <= nx_f[NUM_W-1];
      div_q.bad_y  <= ny_f[NUM_W-1];
      div_q.den    <= den4_q;
      div_q.reason <= r4_q;
    end
  end

  assign valid_o = v_q[2];
  assign div_o   = div_q;

endmodule

`default_nettype wire

@@ rtl/core/pptb_div.sv @@
// Pipelined restoring divider for the x and y pixel numerators over one shared
// denominator; one quotient bit per stage. Depends on pptb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pptb_div #(
  parameter int unsigned QB = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  pptb_pkg::div_in_t  div_i,
  output logic               valid_o,
  output pptb_pkg::div_out_t div_o
);
  import pptb_pkg::*;

  logic [NUM_W-1:0] rem_d [QB+1][2];
  logic [NUM_W-1:0] rem_q [QB+1][2];
  logic [QB-1:0]    quo_d [QB+1][2];
  logic [QB-1:0]    quo_q [QB+1][2];
  logic [DEN_W-1:0] den_q [QB+1];
  logic [1:0]       ovf_d [QB+1];
  logic [1:0]       ovf_q [QB+1];
  cull_e            rsn_q [QB+1];
  logic [QB:0]      vld_q;
  logic [NUM_W-1:0] top_lim;
  logic [NUM_W-1:0] shifted;
  logic             ge;

  always_comb begin
    // Entry: flag quotients that cannot fit QB bits or have a negative numerator.
    top_lim     = NUM_W'(div_i.den) << QB;
    rem_d[0][0] = div_i.num_x;
    rem_d[0][1] = div_i.num_y;
    quo_d[0][0] = '0;
    quo_d[0][1] = '0;
    ovf_d[0][0] = div_i.bad_x | (div_i.num_x >= top_lim);
    ovf_d[0][1] = div_i.bad_y | (div_i.num_y >= top_lim);
    shifted = '0;
    ge      = 1'b0;
    for (int k = 1; k <= QB; k++) begin
      ovf_d[k] = ovf_q[k-1];
      for (int a = 0; a < 2; a++) begin
        shifted     = NUM_W'(den_q[k-1]) << (QB - k);
        ge          = rem_q[k-1][a] >= shifted;
        rem_d[k][a] = ge ? rem_q[k-1][a] - shifted : rem_q[k-1][a];
        quo_d[k][a] = quo_q[k-1][a];
        quo_d[k][a][QB-k] = ge;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= div_i.den;
      rsn_q[0] <= div_i.reason;
      for (int k = 0; k <= QB; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        ovf_q[k] <= ovf_d[k];
      end
      for (int k = 1; k <= QB; k++) begin
        den_q[k] <= den_q[k-1];
        rsn_q[k] <= rsn_q[k-1];
      end
    end
  end

  assign valid_o      = vld_q[QB];
  assign div_o.quo_x  = QUO_W'(quo_q[QB][0]);
  assign div_o.quo_y  = QUO_W'(quo_q[QB][1]);
  assign div_o.rem_x  = rem_q[QB][0][DEN_W-1:0];
  assign div_o.rem_y  = rem_q[QB][1][DEN_W-1:0];
  assign div_o.den    = den_q[QB];
  assign div_o.ovf_x  = ovf_q[QB][0];
  assign div_o.ovf_y  = ovf_q[QB][1];
  assign div_o.reason = rsn_q[QB];

endmodule

`default_nettype wire

@@ rtl/core/pptb_tile.sv @@
// Three-stage back end: round half-to-even and edge test, tile column and row by
// reciprocal multiply, tile index into the output register. Depends on pptb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pptb_tile #(
  parameter int unsigned IMAGE_WIDTH  = 1280,
  parameter int unsigned IMAGE_HEIGHT = 720,
  parameter int unsigned TILE_WIDTH   = 32,
  parameter int unsigned TILE_HEIGHT  = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  pptb_pkg::div_out_t div_i,
  output logic               valid_o,
  output pptb_pkg::result_t  result_o
);
  import pptb_pkg::*;

  localparam int unsigned RECIP_SH     = 24;
  localparam int unsigned PW           = QUO_W + RECIP_SH + 1;
  localparam logic [RECIP_SH:0] RECIP_X = (RECIP_SH+1)'((64'd1 << RECIP_SH) / TILE_WIDTH + 1);
  localparam logic [RECIP_SH:0] RECIP_Y = (RECIP_SH+1)'((64'd1 << RECIP_SH) / TILE_HEIGHT + 1);
  localparam int unsigned GRID_COLS    = (IMAGE_WIDTH + TILE_WIDTH - 1) / TILE_WIDTH;
  localparam logic [QUO_W-1:0] LIM_X   = QUO_W'(IMAGE_WIDTH);
  localparam logic [QUO_W-1:0] LIM_Y   = QUO_W'(IMAGE_HEIGHT);
  localparam logic [QUO_W-1:0] ACROSS  = QUO_W'(GRID_COLS);

  logic             up_x, up_y;
  logic [QUO_W-1:0] px_d, py_d, px_q, py_q;
  cull_e            rr_d, rr_q, rt_q;
  logic [PW-1:0]    prod_x, prod_y;
  logic [QUO_W-1:0] col_q, row_q;
  logic [2*QUO_W-1:0] idx_full;
  result_t          res_q;
  logic [2:0]       v_q;

  always_comb begin
    up_x = ({div_i.rem_x, 1'b0} > {1'b0, div_i.den}) ||
           (({div_i.rem_x, 1'b0} == {1'b0, div_i.den}) && div_i.quo_x[0]);
    up_y = ({div_i.rem_y, 1'b0} > {1'b0, div_i.den}) ||
           (({div_i.rem_y, 1'b0} == {1'b0, div_i.den}) && div_i.quo_y[0]);
    px_d = div_i.quo_x + QUO_W'(up_x);
    py_d = div_i.quo_y + QUO_W'(up_y);
    rr_d = div_i.reason;
    // A pixel that rounds onto the edge is off screen as well.
    if (div_i.reason == CULL_NONE &&
        (div_i.ovf_x || div_i.ovf_y || px_d >= LIM_X || py_d >= LIM_Y)) begin
      rr_d = CULL_OFFSCREEN;
    end
    prod_x   = PW'(px_q) * PW'(RECIP_X);
    prod_y   = PW'(py_q) * PW'(RECIP_Y);
    idx_full = (2*QUO_W)'(row_q) * (2*QUO_W)'(ACROSS) + (2*QUO_W)'(col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      rr_q <= rr_d;

      col_q <= QUO_W'(prod_x >> RECIP_SH);
      row_q <= QUO_W'(prod_y >> RECIP_SH);
      rt_q  <= rr_q;

      res_q.cull_reason <= rt_q;
      if (rt_q == CULL_NONE) begin
        res_q.visible     <= 1'b1;
        res_q.tile_index  <= idx_full[10:0];
        res_q.tile_column <= col_q[5:0];
        res_q.tile_row    <= row_q[5:0];
      end else begin
        res_q.visible     <= 1'b0;
        res_q.tile_index  <= '0;
        res_q.tile_column <= '0;
        res_q.tile_row    <= '0;
      end
    end
  end

  assign valid_o  = v_q[2];
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ rtl/core/point_project_tile_bin.sv @@
// Pipeline: dot product, preparation, pixel divider and tile back end, all registered;
// the divider resolves one quotient bit per stage and grows with the larger image side.
// Throughput: one point per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken.
// Reset: all valid bits clear and every view row resets to zero.
`timescale 1ns / 1ps
`default_nettype none

module point_project_tile_bin #(
  parameter int unsigned IMAGE_WIDTH   = 1280,
  parameter int unsigned IMAGE_HEIGHT  = 720,
  parameter int unsigned TILE_WIDTH    = 32,
  parameter int unsigned TILE_HEIGHT   = 20,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // point transactions
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pptb_pkg::point_t              in_point_i,
  // result transactions
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pptb_pkg::result_t             out_result_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pptb_pkg::ADDR_W-1:0]   paddr,
  input  logic [pptb_pkg::CFG_W-1:0]    pwdata,
  output logic [pptb_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);
  import pptb_pkg::*;

  // Divider depth: enough quotient bits to hold any in-image pixel.
  localparam int unsigned IMG_MAX   = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH
                                                                   : IMAGE_HEIGHT;
  localparam int unsigned QB        = $clog2(IMG_MAX + 1);
  localparam int unsigned GRID_COLS = (IMAGE_WIDTH + TILE_WIDTH - 1) / TILE_WIDTH;
  localparam int unsigned GRID_ROWS = (IMAGE_HEIGHT + TILE_HEIGHT - 1) / TILE_HEIGHT;

  logic [NUM_REGS-1:0][CFG_W-1:0] cfg_q;
  logic        en;
  logic        dot_valid, prep_valid, div_valid;
  dot_sums_t   sums;
  div_in_t     div_in;
  div_out_t    div_out;

  // Register file: written in the APB access phase, read back combinationally.
  assign pready = 1'b1;
  assign prdata = cfg_q[paddr[ADDR_W-1:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      cfg_q[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  // Advance every stage unless a finished result waits at the output.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  pptb_dot #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .point_i(in_point_i),
    .cfg_i  (cfg_q),
    .valid_o(dot_valid),
    .sums_o (sums)
  );

  pptb_prep #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(dot_valid),
    .sums_i (sums),
    .valid_o(prep_valid),
    .div_o  (div_in)
  );

  pptb_div #(
    .QB(QB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(prep_valid),
    .div_i  (div_in),
    .valid_o(div_valid),
    .div_o  (div_out)
  );

  pptb_tile #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .TILE_WIDTH  (TILE_WIDTH),
    .TILE_HEIGHT (TILE_HEIGHT)
  ) u_tile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .div_i   (div_out),
    .valid_o (out_valid_o),
    .result_o(out_result_o)
  );

  // Visibility and cull reason must agree.
  a_visible_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_result_o.visible == (out_result_o.cull_reason == CULL_NONE)))
    else $error("visible flag disagrees with cull reason");

  // Culled points carry no tile.
  a_culled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_result_o.visible) |->
      (out_result_o.tile_index == '0 && out_result_o.tile_column == '0 &&
       out_result_o.tile_row == '0))
    else $error("culled result has nonzero tile fields");

  // A visible point lands inside the tile grid.
  a_tile_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_result_o.visible) |->
      (32'(out_result_o.tile_column) < GRID_COLS &&
       32'(out_result_o.tile_row) < GRID_ROWS))
    else $error("tile coordinates out of grid");

  // A stalled output freezes the whole pipeline, including the divider tail.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(div_valid))
    else $error("pipeline advanced under output stall");

endmodule

`default_nettype wire

@@ sim/pptb_checker.sv @@
// Result checker for point_project_tile_bin: predicts each point's tile and compares.
// Depends on pptb_pkg; driven by tb_top, which mirrors register writes into it.
`timescale 1ns / 1ps

module pptb_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pptb_pkg::point_t  in_point_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pptb_pkg::result_t out_result_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  output int                errors_o,
  output int                pending_o
);
  import pptb_pkg::*;

  localparam int IMG_W = 1280;
  localparam int IMG_H = 720;
  localparam int TILE_W = 32;
  localparam int TILE_H = 20;
  localparam int FRAC = 16;
  localparam int TILES_X = (IMG_W + TILE_W - 1) / TILE_W;
  localparam longint SAT_HI = 64'sd140737488355327;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic [63:0] view_rows [8];
  result_t     tile_queue [$];

  function automatic longint row_dot(logic [63:0] ra, logic [63:0] rb,
                                     longint x, longint y, longint z);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(ra[31:0]));
    c1 = longint'($signed(ra[63:32]));
    c2 = longint'($signed(rb[31:0]));
    c3 = longint'($signed(rb[63:32]));
    // arithmetic shift floors, matching the datapath
    return ((c0 * x) >>> FRAC) + ((c1 * y) >>> FRAC) + ((c2 * z) >>> FRAC) + c3;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Rounded pixel (ties to even); -1 when off the image.
  function automatic longint round_pixel(longint c, longint w, longint s);
    longint num, den, q, r;
    num = s * (c + w) - w;
    den = 2 * w;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num < 0) return -1;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    if (q >= s) return -1;
    return q;
  endfunction

  function automatic result_t project_point(point_t p);
    result_t res;
    longint x, y, z, depth, cx, cy, cw, px, py;
    x = longint'(p.point_x);
    y = longint'(p.point_y);
    z = longint'(p.point_z);
    depth = row_dot(view_rows[6], view_rows[7], x, y, z);
    cx = clamp48(row_dot(view_rows[0], view_rows[1], x, y, z));
    cy = clamp48(row_dot(view_rows[2], view_rows[3], x, y, z));
    cw = clamp48(row_dot(view_rows[4], view_rows[5], x, y, z));
    res = '0;
    px = -1;
    py = -1;
    if (5 * depth <= (64'sd1 << FRAC)) begin
      res.cull_reason = CULL_NEAR;
    end else if (cw == 0) begin
      res.cull_reason = CULL_WZERO;
    end else begin
      px = round_pixel(cx, cw, IMG_W);
      if (px >= 0) py = round_pixel(cy, cw, IMG_H);
      if (px < 0 || py < 0) begin
        res.cull_reason = CULL_OFFSCREEN;
      end else begin
        res.cull_reason = CULL_NONE;
        res.visible = 1'b1;
        res.tile_column = 6'(px / TILE_W);
        res.tile_row = 6'(py / TILE_H);
        res.tile_index = 11'((py / TILE_H) * TILES_X + px / TILE_W);
      end
    end
    return res;
  endfunction

  assign pending_o = tile_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      foreach (view_rows[i]) view_rows[i] = '0;
      tile_queue.delete();
      errors_o <= 0;
    end else begin
      if (cfg_we_i) view_rows[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && in_ready_i) tile_queue = {tile_queue, project_point(in_point_i)};
      if (out_valid_i && out_ready_i) begin
        if (tile_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_result_i);
          errors_o <= errors_o + 1;
        end else begin
          want = tile_queue.pop_front();
          if (want !== out_result_i) begin
            $display("%0t: mismatch expected vis=%0d why=%0d idx=%0d col=%0d row=%0d",
                     $time, want.visible, want.cull_reason, want.tile_index,
                     want.tile_column, want.tile_row);
            $display("%0t:          actual   vis=%0d why=%0d idx=%0d col=%0d row=%0d",
                     $time, out_result_i.visible, out_result_i.cull_reason,
                     out_result_i.tile_index, out_result_i.tile_column,
                     out_result_i.tile_row);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for point_project_tile_bin: clock, reset, register writes, point stimulus.
// Depends on pptb_pkg, the block and pptb_checker; the checker holds prediction.
`timescale 1ns / 1ps

module tb_top;
  import pptb_pkg::*;

  localparam int DRAIN_CYCLES = 60;   // well over the pipeline depth
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  // Register indexes
  localparam int REG_XA = 0;
  localparam int REG_XB = 1;
  localparam int REG_YA = 2;
  localparam int REG_YB = 3;
  localparam int REG_WA = 4;
  localparam int REG_WB = 5;
  localparam int REG_DA = 6;
  localparam int REG_DB = 7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  point_t in_point = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;
  int errors;
  int pending;
  longint cycles = 0;
  logic stall_mode = 1'b0;

  always #6 clk_i = ~clk_i;

  point_project_tile_bin u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_point_i(in_point),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_result_o(out_result),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Mirror a completed register write into the predictor.
  pptb_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_point_i(in_point),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_result_i(out_result),
    .cfg_we_i(psel && penable && pwrite && pready),
    .cfg_idx_i(paddr[5:3]), .cfg_data_i(pwdata),
    .errors_o(errors), .pending_o(pending)
  );

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("point_project_tile_bin verification failed");
      $finish;
    end
  end

  // Receiver: alternate between a free-flowing stretch and random stalls.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  task automatic write_reg(int idx, logic [63:0] val);
    // setup phase, then access phase
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx * 8);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  // Write all rows back to back, then release the bus.
  task automatic load_view(logic [63:0] rows [8]);
    for (int i = 0; i < 8; i++) write_reg(i, rows[i]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one point and hold it until the block takes it.
  task automatic send_point(point_t p);
    in_valid <= 1'b1;
    in_point <= p;
    do @(posedge clk_i); while (!in_ready);
    in_valid <= 1'b0;
  endtask

  // Wait out every expected result, then the pipeline tail.
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 20 * 65536)) - 20 * 65536);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Mostly points in front of the camera with modest extents.
  function automatic point_t rand_point();
    point_t p;
    if ($urandom_range(0, 9) < 7) begin
      p.point_x = 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
      p.point_y = 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
      p.point_z = 32'($urandom_range(0, 40 * 65536));
    end else begin
      p = {rand_word(), rand_word(), rand_word()};
    end
    return p;
  endfunction

  initial begin
    logic [63:0] view [8];
    point_t p;
    int burst;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Simple pinhole view: clip x = x, y = y, w = z, depth = z.
    view[REG_XA] = {32'h0, ONE};
    view[REG_XB] = 64'h0;
    view[REG_YA] = {ONE, 32'h0};
    view[REG_YB] = 64'h0;
    view[REG_WA] = 64'h0;
    view[REG_WB] = {32'h0, ONE};
    view[REG_DA] = 64'h0;
    view[REG_DB] = {32'h0, ONE};
    load_view(view);

    // Directed: near plane boundary, w zero, edges, rounding ties, extremes.
    send_point('{32'sh0, 32'sh0, 32'sd13107});          // depth 0.19999 -> near
    send_point('{32'sh0, 32'sh0, 32'sd13108});          // just past near plane
    send_point('{32'sh0, 32'sh0, ONE});                 // center
    send_point('{-32'sd65536, -32'sd65536, ONE});       // top-left corner
    send_point('{32'sd65535, 32'sd65535, ONE});         // near right/bottom edge
    send_point('{32'sd65536, 32'sd65536, ONE});         // rounds onto the edge
    send_point('{-32'sd65600, 32'sh0, ONE});            // left of image
    send_point('{32'sd1, 32'sd1, ONE});                 // half-pixel tie region
    send_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    send_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    send_point('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    send_point('{32'sh0, 32'sh0, 32'sh8000_0000});      // behind camera
    send_point('{32'sh1234_5678, -32'sd4096, 32'sd3 * ONE});
    drain();

    // w row zero with depth positive: every point hits the w-zero cull.
    view[REG_WB] = 64'h0;
    view[REG_DB] = {ONE, 32'h0};
    load_view(view);
    send_point('{32'sh0, 32'sh0, 32'sh0});
    send_point('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1});
    drain();

    // Extreme rows: saturate the clip values, all-ones registers, then extreme coefficients.
    foreach (view[i]) view[i] = 64'hFFFF_FFFF_FFFF_FFFF;
    view[REG_DB] = {ONE, 32'h7FFF_FFFF};
    load_view(view);
    send_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    send_point('{32'sh8000_0000, 32'sh0, 32'sh0});
    drain();
    foreach (view[i]) view[i] = {32'h7FFF_FFFF, 32'h8000_0000};
    load_view(view);
    send_point('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    send_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    drain();

    // Random phases: several view settings, bursty points.
    for (int phase = 0; phase < 7; phase++) begin
      if (phase % 3 == 2) begin
        foreach (view[i]) view[i] = {rand_word(), rand_word()};
      end else begin
        // perspective-like rows with random scale, flips and offsets
        view[REG_XA] = {32'($signed($urandom_range(0, 8192)) - 4096),
                        32'($urandom_range(16384, 3 * 65536))};
        view[REG_XB] = {32'($signed($urandom_range(0, 32768)) - 16384),
                        32'($signed($urandom_range(0, 16384)) - 8192)};
        view[REG_YA] = {32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536),
                        32'($signed($urandom_range(0, 8192)) - 4096)};
        view[REG_YB] = {32'($signed($urandom_range(0, 32768)) - 16384),
                        32'($signed($urandom_range(0, 16384)) - 8192)};
        view[REG_WA] = {32'($signed($urandom_range(0, 2048)) - 1024),
                        32'($signed($urandom_range(0, 2048)) - 1024)};
        view[REG_WB] = {32'($signed($urandom_range(0, 65536)) - 32768),
                        $urandom_range(0, 1) ? ONE : -ONE};
        view[REG_DA] = view[REG_WA];
        view[REG_DB] = {32'($signed($urandom_range(0, 65536)) - 32768), ONE};
      end
      load_view(view);
      for (int n = 0; n < 200; ) begin
        burst = $urandom_range(1, 30);
        for (int k = 0; k < burst && n < 200; k++, n++) begin
          p = rand_point();
          if (phase % 3 == 2 && $urandom_range(0, 1)) p = {rand_word(), rand_word(), rand_word()};
          in_valid <= 1'b1;
          in_point <= p;
          do @(posedge clk_i); while (!in_ready);
        end
        in_valid <= 1'b0;
        if ($urandom_range(0, 15) == 0) begin
          // hold until every expected result has come back
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end else begin
          repeat ($urandom_range(0, 8)) @(posedge clk_i);
        end
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("point_project_tile_bin verification clean");
    end else begin
      $display("point_project_tile_bin verification failed");
    end
    $finish;
  end

endmodule
